### rtl/core/bqj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqj_pkg
// Widths, constants and interstage types of the bilinear quad Jacobian block.
// ----------------------------------------------------------------------------
package bqj_pkg;

  localparam int CW      = 34;          // four times a bilinear coefficient
  localparam int DVW     = 50;          // derivative, scale 2^-32
  localparam int HW      = DVW / 2;     // multiplier half width
  localparam int PRW     = 2 * DVW;     // unsigned derivative product
  localparam int PW      = PRW + 2;     // signed determinant, scale 2^-64
  localparam int PUW     = PRW;         // determinant magnitude when positive
  localparam int DW      = PUW + 32;    // divider remainder width
  localparam int QW      = 32;          // quotient width
  localparam int DIV_LAT = QW + 2;      // divider stages
  localparam int LAT     = 8 + DIV_LAT; // request to result
  localparam int SUMW    = 35;          // sum of coordinate magnitudes
  localparam int TOLW    = SUMW + 16;
  localparam int CMPW    = CW + 33;
  localparam int WPW     = 40;          // one weight partial product
  localparam int WSW     = 116;         // full weighted product

  localparam logic [63:0] SAT64   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [15:0] TOL_RST = 16'd1;

  typedef struct packed {
    logic signed [DVW-1:0] dxdr;
    logic signed [DVW-1:0] dxds;
    logic signed [DVW-1:0] dydr;
    logic signed [DVW-1:0] dyds;
    logic [14:0]           w;
    logic                  para;
  } drv_t;

  typedef struct packed {
    logic signed [PW-1:0]  p;
    logic [3:0][DVW-1:0]   nmag;
    logic [3:0]            nneg;
    logic [14:0]           w;
    logic                  para;
  } det_t;

  typedef struct packed {
    logic [63:0] det;
    logic [63:0] wdet;
    logic        para;
    logic        bad;
  } side_t;

endpackage

### rtl/core/bqj_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqj_front
// Bilinear coefficients, derivatives at (r, s) and the parallelogram test.
// ----------------------------------------------------------------------------
module bqj_front import bqj_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [3:0][31:0]    vx,
  input  logic [3:0][31:0]    vy,
  input  logic signed [15:0]  r,
  input  logic signed [15:0]  s,
  input  logic [14:0]         w,
  input  logic [15:0]         tol_f,
  output logic                drv_vld,
  output drv_t                drv
);

  logic signed [CW-1:0] ex [4];
  logic signed [CW-1:0] ey [4];
  logic [31:0]          mag [8];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ex[k] = {{(CW-32){vx[k][31]}}, vx[k]};
      ey[k] = {{(CW-32){vy[k][31]}}, vy[k]};
      mag[2*k]   = vx[k][31] ? 32'(~vx[k] + 32'd1) : vx[k];
      mag[2*k+1] = vy[k][31] ? 32'(~vy[k] + 32'd1) : vy[k];
    end
  end

  // Stage 1
  logic signed [CW-1:0] a1_r, a2_r, a3_r, b1_r, b2_r, b3_r;
  logic [31:0]          mag_r [8];
  logic signed [15:0]   r_r, s_r;
  logic [14:0]          w1_r;
  logic                 v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    a1_r <= -ex[0] + ex[1] + ex[2] - ex[3];
    a2_r <= -ex[0] - ex[1] + ex[2] + ex[3];
    a3_r <=  ex[0] - ex[1] + ex[2] - ex[3];
    b1_r <= -ey[0] + ey[1] + ey[2] - ey[3];
    b2_r <= -ey[0] - ey[1] + ey[2] + ey[3];
    b3_r <=  ey[0] - ey[1] + ey[2] - ey[3];
    for (int k = 0; k < 8; k++) mag_r[k] <= mag[k];
    r_r  <= r;
    s_r  <= s;
    w1_r <= w;
  end

  // Stage 2
  logic signed [DVW-1:0] dxdr_nxt, dxds_nxt, dydr_nxt, dyds_nxt;
  logic [SUMW-1:0]       sum_nxt;
  logic signed [DVW-1:0] dxdr_r, dxds_r, dydr_r, dyds_r;
  logic [SUMW-1:0]       sum_r;
  logic [CW-1:0]         a3m_r, b3m_r;
  logic [14:0]           w2_r;
  logic                  v2_r;

  always_comb begin
    dxdr_nxt = (DVW'(a1_r) <<< 14) + DVW'(a3_r) * DVW'(s_r);
    dxds_nxt = (DVW'(a2_r) <<< 14) + DVW'(a3_r) * DVW'(r_r);
    dydr_nxt = (DVW'(b1_r) <<< 14) + DVW'(b3_r) * DVW'(s_r);
    dyds_nxt = (DVW'(b2_r) <<< 14) + DVW'(b3_r) * DVW'(r_r);
    sum_nxt  = SUMW'(32'd65536);
    for (int k = 0; k < 8; k++) sum_nxt = sum_nxt + SUMW'(mag_r[k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    dxdr_r <= dxdr_nxt;
    dxds_r <= dxds_nxt;
    dydr_r <= dydr_nxt;
    dyds_r <= dyds_nxt;
    sum_r  <= sum_nxt;
    // The parallelogram conditions equal the cross coefficients a3 and b3.
    a3m_r  <= a3_r[CW-1] ? CW'(-a3_r) : CW'(a3_r);
    b3m_r  <= b3_r[CW-1] ? CW'(-b3_r) : CW'(b3_r);
    w2_r   <= w1_r;
  end

  // Stage 3
  logic [TOLW-1:0] tol;
  logic [CMPW-1:0] cx_sh, cy_sh;
  drv_t            drv_r;
  logic            v3_r;

  assign tol   = TOLW'(tol_f) * TOLW'(sum_r);
  assign cx_sh = {1'b0, a3m_r, 32'd0};
  assign cy_sh = {1'b0, b3m_r, 32'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    drv_r.dxdr <= dxdr_r;
    drv_r.dxds <= dxds_r;
    drv_r.dydr <= dydr_r;
    drv_r.dyds <= dyds_r;
    drv_r.w    <= w2_r;
    drv_r.para <= (CMPW'(tol) >= cx_sh) && (CMPW'(tol) >= cy_sh);
  end

  assign drv_vld = v3_r;
  assign drv     = drv_r;

endmodule

### rtl/core/bqj_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqj_det
// Exact Jacobian determinant from split partial products over four stages.
// ----------------------------------------------------------------------------
module bqj_det import bqj_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic drv_vld,
  input  drv_t drv,
  output logic det_vld,
  output det_t det
);

  // Derivative order: dxdr, dxds, dydr, dyds.
  logic signed [DVW-1:0] d [4];
  assign d[0] = drv.dxdr;
  assign d[1] = drv.dxds;
  assign d[2] = drv.dydr;
  assign d[3] = drv.dyds;

  // Stage 4: magnitudes and signs
  logic [DVW-1:0] m4_r [4];
  logic [3:0]     n4_r;
  logic [14:0]    w4_r;
  logic           p4_r, v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= drv_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      m4_r[k] <= d[k][DVW-1] ? DVW'(-d[k]) : DVW'(d[k]);
      n4_r[k] <= d[k][DVW-1];
    end
    w4_r <= drv.w;
    p4_r <= drv.para;
  end

  // Stage 5: half-width partial products of dxdr*dyds and dxds*dydr
  logic [2*HW-1:0] pa_r [4];
  logic [2*HW-1:0] pb_r [4];
  logic [DVW-1:0]  m5_r [4];
  logic [3:0]      n5_r;
  logic [14:0]     w5_r;
  logic            p5_r, v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    pa_r[0] <= m4_r[0][HW-1:0]  * m4_r[3][HW-1:0];
    pa_r[1] <= m4_r[0][HW-1:0]  * m4_r[3][DVW-1:HW];
    pa_r[2] <= m4_r[0][DVW-1:HW] * m4_r[3][HW-1:0];
    pa_r[3] <= m4_r[0][DVW-1:HW] * m4_r[3][DVW-1:HW];
    pb_r[0] <= m4_r[1][HW-1:0]  * m4_r[2][HW-1:0];
    pb_r[1] <= m4_r[1][HW-1:0]  * m4_r[2][DVW-1:HW];
    pb_r[2] <= m4_r[1][DVW-1:HW] * m4_r[2][HW-1:0];
    pb_r[3] <= m4_r[1][DVW-1:HW] * m4_r[2][DVW-1:HW];
    for (int k = 0; k < 4; k++) m5_r[k] <= m4_r[k];
    n5_r <= n4_r;
    w5_r <= w4_r;
    p5_r <= p4_r;
  end

  // Stage 6: full unsigned products
  logic [PRW-1:0] pra_r, prb_r;
  logic [DVW-1:0] m6_r [4];
  logic [3:0]     n6_r;
  logic [14:0]    w6_r;
  logic           p6_r, v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    pra_r <= PRW'(pa_r[0]) + (PRW'(pa_r[1]) << HW) + (PRW'(pa_r[2]) << HW)
           + (PRW'(pa_r[3]) << (2*HW));
    prb_r <= PRW'(pb_r[0]) + (PRW'(pb_r[1]) << HW) + (PRW'(pb_r[2]) << HW)
           + (PRW'(pb_r[3]) << (2*HW));
    for (int k = 0; k < 4; k++) m6_r[k] <= m5_r[k];
    n6_r <= n5_r;
    w6_r <= w5_r;
    p6_r <= p5_r;
  end

  // Stage 7: signed difference
  logic signed [PW-1:0] ta, tb;
  det_t                 det_r;
  logic                 v7_r;

  assign ta = signed'(PW'(pra_r));
  assign tb = signed'(PW'(prb_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    det_r.p <= ((n6_r[0] ^ n6_r[3]) ? -ta : ta) - ((n6_r[1] ^ n6_r[2]) ? -tb : tb);
    // Numerators of the inverse: dyds, -dxds, -dydr, dxdr.
    det_r.nmag[0] <= m6_r[3];
    det_r.nneg[0] <= n6_r[3];
    det_r.nmag[1] <= m6_r[1];
    det_r.nneg[1] <= ~n6_r[1];
    det_r.nmag[2] <= m6_r[2];
    det_r.nneg[2] <= ~n6_r[2];
    det_r.nmag[3] <= m6_r[0];
    det_r.nneg[3] <= n6_r[0];
    det_r.w       <= w6_r;
    det_r.para    <= p6_r;
  end

  assign det_vld = v7_r;
  assign det     = det_r;

endmodule

### rtl/core/bqj_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqj_div
// Pipelined restoring divider, one quotient bit per stage, saturating result.
// ----------------------------------------------------------------------------
module bqj_div import bqj_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [DW-1:0]   num,
  input  logic [PUW-1:0]  den,
  input  logic            neg,
  output logic            out_vld,
  output logic [QW-1:0]   res
);

  logic [DW-1:0]  rem_r [QW+1];
  logic [PUW-1:0] den_r [QW+1];
  logic [QW-1:0]  q_r   [QW+1];
  logic           sat_r [QW+1];
  logic           neg_r [QW+1];
  logic           v_r   [QW+1];

  // Stage 0 flags quotients that do not fit in the result width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    den_r[0] <= den;
    q_r[0]   <= '0;
    sat_r[0] <= num >= (DW'(den) << QW);
    neg_r[0] <= neg;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int SH = QW - k;
    logic [DW-1:0] dsh;
    logic          ge;

    assign dsh = DW'(den_r[k-1]) << SH;
    assign ge  = rem_r[k-1] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? rem_r[k-1] - dsh : rem_r[k-1];
      den_r[k] <= den_r[k-1];
      q_r[k]   <= {q_r[k-1][QW-2:0], ge};
      sat_r[k] <= sat_r[k-1];
      neg_r[k] <= neg_r[k-1];
    end
  end

  logic [QW-1:0] lim, mag;
  logic [QW-1:0] res_r;
  logic          vo_r;

  assign lim = neg_r[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
  assign mag = (sat_r[QW] || (q_r[QW] > lim)) ? lim : q_r[QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= neg_r[QW] ? QW'(~mag + 1'b1) : mag;
  end

  assign out_vld = vo_r;
  assign res     = res_r;

endmodule

### rtl/core/bilinear_quad_jacobian.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_quad_jacobian
// Jacobian determinant, inverse and weighted determinant of a bilinear quad.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy is always low since the pipeline
// never stalls, and the 34 stages of the inverse dividers take most of the depth.
// Reset (synchronous, active low) clears all valid bits and sets the
// tolerance factor to 1; results in flight are dropped.
module bilinear_quad_jacobian import bqj_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_vert0_x,
  input  logic signed [31:0] in_vert0_y,
  input  logic signed [31:0] in_vert1_x,
  input  logic signed [31:0] in_vert1_y,
  input  logic signed [31:0] in_vert2_x,
  input  logic signed [31:0] in_vert2_y,
  input  logic signed [31:0] in_vert3_x,
  input  logic signed [31:0] in_vert3_y,
  input  logic signed [15:0] in_ref_r,
  input  logic signed [15:0] in_ref_s,
  input  logic [14:0]        in_quad_weight,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [63:0] out_det_jacobian,
  output logic signed [31:0] out_inv_j11,
  output logic signed [31:0] out_inv_j12,
  output logic signed [31:0] out_inv_j21,
  output logic signed [31:0] out_inv_j22,
  output logic signed [63:0] out_weighted_det,
  output logic               out_is_parallelogram,
  output logic               out_bad_jacobian
);

  logic        accept;
  logic [15:0] tol_f_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_f_r <= TOL_RST;
    end else if (cfg_we) begin
      tol_f_r <= cfg_wdata;
    end
  end

  drv_t drv;
  logic drv_vld;
  det_t det;
  logic det_vld;

  bqj_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .vx      ({in_vert3_x, in_vert2_x, in_vert1_x, in_vert0_x}),
    .vy      ({in_vert3_y, in_vert2_y, in_vert1_y, in_vert0_y}),
    .r       (in_ref_r),
    .s       (in_ref_s),
    .w       (in_quad_weight),
    .tol_f   (tol_f_r),
    .drv_vld (drv_vld),
    .drv     (drv)
  );

  bqj_det u_det (
    .clk     (clk),
    .rst_n   (rst_n),
    .drv_vld (drv_vld),
    .drv     (drv),
    .det_vld (det_vld),
    .det     (det)
  );

  // Stage 8: rounding of the determinant, weight partials, divider operands.
  logic [PUW-1:0] pu;
  logic [PUW:0]   dround;
  logic [68:0]    dsh;

  assign pu     = det.p[PUW-1:0];
  assign dround = (PUW+1)'(pu) + (PUW+1)'(32'h8000_0000);
  assign dsh    = dround[PUW:32];

  logic [DW-1:0]  num8_r [4];
  logic [3:0]     neg8_r;
  logic [PUW-1:0] den8_r;
  logic [WPW-1:0] wpp8_r [4];
  logic [63:0]    det8_r;
  logic           bad8_r, para8_r, v8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= det_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      num8_r[k] <= (DW'(det.nmag[k]) << 48) + DW'(pu >> 1);
      wpp8_r[k] <= WPW'(pu[25*k +: 25]) * WPW'(det.w);
    end
    neg8_r  <= det.nneg;
    den8_r  <= pu;
    det8_r  <= (|dsh[68:63]) ? SAT64 : dsh[63:0];
    bad8_r  <= det.p[PW-1] || (det.p == '0);
    para8_r <= det.para;
  end

  logic [3:0]    dv;
  logic [QW-1:0] inv [4];

  for (genvar k = 0; k < 4; k++) begin : g_div
    bqj_div u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (v8_r),
      .num     (num8_r[k]),
      .den     (den8_r),
      .neg     (neg8_r[k]),
      .out_vld (dv[k]),
      .res     (inv[k])
    );
  end

  // Stage 9: weighted determinant, then a delay line matching the divider.
  logic [WSW-1:0] pw;
  logic [69:0]    wsh;

  always_comb begin
    pw = WSW'(64'h2000_0000_0000);
    for (int k = 0; k < 4; k++) pw = pw + (WSW'(wpp8_r[k]) << (25*k));
    wsh = pw[WSW-1:46];
  end

  side_t sd_r [DIV_LAT];

  always_ff @(posedge clk) begin
    sd_r[0].det  <= det8_r;
    sd_r[0].wdet <= (|wsh[69:63]) ? SAT64 : wsh[63:0];
    sd_r[0].para <= para8_r;
    sd_r[0].bad  <= bad8_r;
    for (int k = 1; k < DIV_LAT; k++) sd_r[k] <= sd_r[k-1];
  end

  side_t sd;
  assign sd = sd_r[DIV_LAT-1];

  assign out_valid            = dv[0];
  assign out_bad_jacobian     = sd.bad;
  assign out_det_jacobian     = sd.bad ? '0 : signed'(sd.det);
  assign out_weighted_det     = sd.bad ? '0 : signed'(sd.wdet);
  assign out_is_parallelogram = sd.bad ? 1'b0 : sd.para;
  assign out_inv_j11          = sd.bad ? '0 : signed'(inv[0]);
  assign out_inv_j12          = sd.bad ? '0 : signed'(inv[1]);
  assign out_inv_j21          = sd.bad ? '0 : signed'(inv[2]);
  assign out_inv_j22          = sd.bad ? '0 : signed'(inv[3]);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted request did not produce a result on time");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##LAT !out_valid)
    else $error("result strobe without a matching request");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (dv == 4'b0000) || (dv == 4'b1111))
    else $error("inverse divider lanes out of step");

  a_good_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_jacobian |-> !out_det_jacobian[63] && !out_weighted_det[63])
    else $error("good Jacobian reported with negative determinant");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bilinear quadrilateral Jacobian block.
// A queue of requests, drain markers and tolerance writes feeds a clocked
// driver. A clocked monitor predicts each accepted request with wide integer
// arithmetic and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import bqj_pkg::*;

  typedef enum logic [1:0] {K_REQ, K_DRAIN, K_CFG} kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0][31:0] coord;   // x0, y0, x1, y1, x2, y2, x3, y3
    logic [15:0]      r;
    logic [15:0]      s;
    logic [14:0]      w;
    logic [15:0]      tol;
  } req_t;

  typedef struct packed {
    logic [63:0]      det;
    logic [3:0][31:0] inv;
    logic [63:0]      wdet;
    logic             para;
    logic             bad;
  } jac_t;

  localparam int WATCHDOG = 5000;
  localparam logic [127:0] SAT_POS = 128'h7FFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0][31:0] drv_coord = '0;
  logic [15:0] drv_r = '0, drv_s = '0;
  logic [14:0] drv_w = '0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic out_valid, out_is_parallelogram, out_bad_jacobian;
  logic signed [63:0] out_det_jacobian, out_weighted_det;
  logic signed [31:0] out_inv_j11, out_inv_j12, out_inv_j21, out_inv_j22;

  req_t pending_reqs[$];
  jac_t expected_jacs[$];
  logic [15:0] tol_factor = TOL_RST;
  logic req_taken = 1'b0;
  int errors = 0;
  int sent = 0;
  int results_seen = 0;
  int drain_cnt = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  bilinear_quad_jacobian uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vert0_x(drv_coord[0]), .in_vert0_y(drv_coord[1]),
    .in_vert1_x(drv_coord[2]), .in_vert1_y(drv_coord[3]),
    .in_vert2_x(drv_coord[4]), .in_vert2_y(drv_coord[5]),
    .in_vert3_x(drv_coord[6]), .in_vert3_y(drv_coord[7]),
    .in_ref_r(drv_r), .in_ref_s(drv_s), .in_quad_weight(drv_w),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_det_jacobian(out_det_jacobian),
    .out_inv_j11(out_inv_j11), .out_inv_j12(out_inv_j12),
    .out_inv_j21(out_inv_j21), .out_inv_j22(out_inv_j22),
    .out_weighted_det(out_weighted_det),
    .out_is_parallelogram(out_is_parallelogram),
    .out_bad_jacobian(out_bad_jacobian)
  );

  function automatic logic [127:0] mag128(longint v);
    logic signed [127:0] t;
    t = 128'(v);
    return (t < 0) ? -t : t;
  endfunction

  // Exact determinant with scale 2^-64, then rounded and saturated outputs.
  function automatic jac_t jacobian_at(req_t q, logic [15:0] f);
    longint x[4], y[4], nums[4];
    longint r, s, a1, a2, a3, b1, b2, b3, dxdr, dxds, dydr, dyds, cx, cy;
    logic signed [127:0] w1, w2, w3, w4, p;
    logic [127:0] up, d, n, qt, sum, tol, tx, ty;
    jac_t res;
    res = '0;
    sum = 128'd65536;
    for (int k = 0; k < 4; k++) begin
      x[k] = longint'($signed(q.coord[2*k]));
      y[k] = longint'($signed(q.coord[2*k+1]));
      sum += mag128(x[k]) + mag128(y[k]);
    end
    r = longint'($signed(q.r));
    s = longint'($signed(q.s));
    a1 = -x[0] + x[1] + x[2] - x[3];
    a2 = -x[0] - x[1] + x[2] + x[3];
    a3 = x[0] - x[1] + x[2] - x[3];
    b1 = -y[0] + y[1] + y[2] - y[3];
    b2 = -y[0] - y[1] + y[2] + y[3];
    b3 = y[0] - y[1] + y[2] - y[3];
    dxdr = a1 * 16384 + a3 * s;
    dxds = a2 * 16384 + a3 * r;
    dydr = b1 * 16384 + b3 * s;
    dyds = b2 * 16384 + b3 * r;
    w1 = 128'(dxdr); w2 = 128'(dxds); w3 = 128'(dydr); w4 = 128'(dyds);
    p = w1 * w4 - w2 * w3;
    if (p <= 0) begin
      res.bad = 1'b1;
      return res;
    end
    up = p;
    d = (up + (128'd1 << 31)) >> 32;
    res.det = (d > SAT_POS) ? SAT_POS[63:0] : d[63:0];
    nums[0] = dyds; nums[1] = -dxds; nums[2] = -dydr; nums[3] = dxdr;
    for (int k = 0; k < 4; k++) begin
      n = (mag128(nums[k]) << 48) + (up >> 1);
      qt = n / up;
      if (nums[k] < 0) begin
        if (qt > 128'h8000_0000) qt = 128'h8000_0000;
        res.inv[k] = -qt[31:0];
      end else begin
        res.inv[k] = (qt > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : qt[31:0];
      end
    end
    d = (up * q.w + (128'd1 << 45)) >> 46;
    res.wdet = (d > SAT_POS) ? SAT_POS[63:0] : d[63:0];
    cx = (x[0] + x[2]) - (x[1] + x[3]);
    cy = (y[0] + y[2]) - (y[1] + y[3]);
    tol = f * sum;
    tx = mag128(cx) << 32;
    ty = mag128(cy) << 32;
    res.para = (tol >= tx) && (tol >= ty);
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", results_seen, field, got, want);
    errors++;
  endtask

  task automatic push_quad(logic [7:0][31:0] c, logic [15:0] r, logic [15:0] s,
                           logic [14:0] w);
    req_t q;
    q = '0;
    q.kind = K_REQ; q.coord = c; q.r = r; q.s = s; q.w = w;
    pending_reqs.push_back(q);
  endtask

  task automatic push_tol(logic [15:0] value);
    req_t q;
    q = '0;
    q.kind = K_DRAIN;
    pending_reqs.push_back(q);
    q.kind = K_CFG; q.tol = value;
    pending_reqs.push_back(q);
  endtask

  // Mostly well-shaped quads around a random center; some are parallelograms,
  // some are mirrored, and a few are raw bit patterns.
  task automatic push_random_quad();
    logic [7:0][31:0] c;
    int cxo, cyo, h, jit, sel;
    logic [15:0] r, s;
    sel = $urandom_range(99);
    if (sel < 12) begin
      for (int k = 0; k < 8; k++) c[k] = $urandom();
    end else begin
      h = $urandom_range(1, 1 << $urandom_range(0, 24));
      cxo = $signed($urandom()) >>> 2;
      cyo = $signed($urandom()) >>> 2;
      jit = h / 3 + 1;
      c[0] = cxo - h; c[1] = cyo - h;
      c[2] = cxo + h; c[3] = cyo - h;
      c[4] = cxo + h; c[5] = cyo + h;
      c[6] = cxo - h; c[7] = cyo + h;
      for (int k = 0; k < 8; k++)
        c[k] = c[k] + $signed($urandom_range(0, 2 * jit)) - jit;
      if (sel < 45) begin
        // Close P2 so that P0 + P2 = P1 + P3, then nudge it a little.
        c[4] = c[2] + c[6] - c[0] + $urandom_range(0, 1 << $urandom_range(0, 12));
        c[5] = c[3] + c[7] - c[1] + $urandom_range(0, 1 << $urandom_range(0, 12));
      end
      if (sel >= 90) begin
        c = {c[1:0], c[3:2], c[5:4], c[7:6]};
      end
    end
    if ($urandom_range(9) == 0) begin
      r = 16'($urandom()); s = 16'($urandom());
    end else begin
      r = 16'($urandom_range(32768) - 16384);
      s = 16'($urandom_range(32768) - 16384);
    end
    push_quad(c, r, s, 15'($urandom()));
  endtask

  // Driver: requests and tolerance writes change at the falling edge.
  always @(negedge clk) begin
    logic nxt_start, nxt_we;
    req_t head;
    nxt_start = start;
    nxt_we = 1'b0;
    if (rst_n) begin
      if (start && req_taken) nxt_start = 1'b0;
      if (!nxt_start) begin
        if (drain_cnt > 0) begin
          drain_cnt--;
        end else if (pending_reqs.size() > 0) begin
          head = pending_reqs[0];
          case (head.kind)
            K_REQ: begin
              if ((sent >= 700 && sent < 1000) || $urandom_range(99) >= 14) begin
                drv_coord <= head.coord;
                drv_r <= head.r;
                drv_s <= head.s;
                drv_w <= head.w;
                nxt_start = 1'b1;
                sent++;
                void'(pending_reqs.pop_front());
              end
            end
            K_DRAIN: begin
              if (expected_jacs.size() == 0 && !start) begin
                drain_cnt = LAT + 4;
                void'(pending_reqs.pop_front());
              end
            end
            default: begin
              cfg_wdata <= head.tol;
              nxt_we = 1'b1;
              void'(pending_reqs.pop_front());
            end
          endcase
        end
      end
    end
    start <= nxt_start;
    cfg_we <= nxt_we;
  end

  // Monitor: predicts at acceptance and checks each strobed result.
  always @(posedge clk) begin
    jac_t got, want;
    req_t q;
    if (!rst_n) begin
      tol_factor = TOL_RST;
      req_taken = 1'b0;
    end else begin
      if (cfg_we) tol_factor = cfg_wdata;
      req_taken = start && !busy;
      if (req_taken) begin
        q = '0;
        q.coord = drv_coord; q.r = drv_r; q.s = drv_s; q.w = drv_w;
        expected_jacs.push_back(jacobian_at(q, tol_factor));
      end
      if (out_valid) begin
        got.det = out_det_jacobian;
        got.inv = {out_inv_j22, out_inv_j21, out_inv_j12, out_inv_j11};
        got.wdet = out_weighted_det;
        got.para = out_is_parallelogram;
        got.bad = out_bad_jacobian;
        if (expected_jacs.size() == 0) begin
          $display("MISMATCH unexpected result %0d", results_seen);
          errors++;
        end else begin
          want = expected_jacs.pop_front();
          if (got.det !== want.det) report_mismatch("det_jacobian", got.det, want.det);
          for (int k = 0; k < 4; k++)
            if (got.inv[k] !== want.inv[k])
              report_mismatch($sformatf("inv_entry%0d", k), 64'(got.inv[k]),
                              64'(want.inv[k]));
          if (got.wdet !== want.wdet)
            report_mismatch("weighted_det", got.wdet, want.wdet);
          if (got.para !== want.para)
            report_mismatch("is_parallelogram", 64'(got.para), 64'(want.para));
          if (got.bad !== want.bad)
            report_mismatch("bad_jacobian", 64'(got.bad), 64'(want.bad));
        end
        results_seen++;
      end
      if (req_taken || out_valid || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0][31:0] sq, c;
    logic [15:0] phase_tol[5];
    sq = {32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536,
          -32'sd65536, 32'sd65536, -32'sd65536, -32'sd65536};
    // Directed requests under the reset tolerance.
    push_quad('0, 16'd0, 16'd0, 15'h7FFF);
    push_quad(sq, 16'd0, 16'd0, 15'h7FFF);
    push_quad({sq[1:0], sq[3:2], sq[5:4], sq[7:6]}, 16'd0, 16'd0, 15'd16384);
    push_quad(sq, -16'sd16384, 16'sd16384, 15'd0);
    push_quad(sq, 16'sd16384, -16'sd16384, 15'd1);
    push_quad(sq, 16'h8000, 16'h7FFF, 15'h4000);
    push_quad(sq, 16'h7FFF, 16'h8000, 15'h2AAA);
    c = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
    push_quad(c, 16'd0, 16'd0, 15'h7FFF);
    push_quad(c, 16'sd16384, 16'sd16384, 15'h7FFF);
    // A one-LSB square: positive determinant that rounds to zero.
    c = {32'd1, 32'd0, 32'd1, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0};
    push_quad(c, 16'd0, 16'd0, 15'h7FFF);
    // Trapezoid, not a parallelogram.
    c = {32'sd65536, -32'sd32768, 32'sd65536, 32'sd32768,
         -32'sd65536, 32'sd65536, -32'sd65536, -32'sd65536};
    push_quad(c, 16'sd8192, -16'sd8192, 15'd16384);
    // Collinear points give a zero determinant.
    c = {32'sd3, 32'sd3, 32'sd2, 32'sd2, 32'sd1, 32'sd1, 32'sd0, 32'sd0};
    push_quad(c, 16'd0, 16'd0, 15'd100);
    // Rectangle from y = -1 to one LSB above zero: inverse entries within range.
    c = {32'sd1, -32'sd65536, 32'sd1, 32'sd65536,
         -32'sd65536, 32'sd65536, -32'sd65536, -32'sd65536};
    push_quad(c, 16'd0, 16'd0, 15'd16384);
    push_quad({8{32'h8000_0000}}, 16'd0, 16'd0, 15'h7FFF);
    push_quad({8{32'hFFFF_FFFF}}, 16'hFFFF, 16'hFFFF, 15'h7FFF);
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 8; j++) c[j] = $urandom();
      push_quad(c, 16'($urandom()), 16'($urandom()), 15'($urandom()));
    end
    phase_tol[0] = 16'd0;
    phase_tol[1] = 16'hFFFF;
    phase_tol[2] = 16'd1;
    phase_tol[3] = 16'($urandom());
    phase_tol[4] = 16'($urandom_range(1, 255));
    for (int ph = 0; ph < 5; ph++) begin
      push_tol(phase_tol[ph]);
      for (int k = 0; k < 310; k++) push_random_quad();
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && !start && expected_jacs.size() == 0);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
